>>> src/efr_pkg.sv
// efr_pkg: shared constants and types of the edge function triangle fill core
// depends on nothing
`timescale 1ns / 1ps

package efr_pkg;

   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 128;
   localparam int FRAC_BITS     = 16;
   localparam int PIXEL_COUNT   = SCREEN_WIDTH * SCREEN_HEIGHT;

   localparam int CW  = 32;                       // vertex coordinate width
   localparam int DW  = CW + 1;                   // difference width
   localparam int PW  = 2 * DW;                   // product width
   localparam int EW  = 64;                       // edge value width
   localparam int XW  = $clog2(SCREEN_WIDTH);
   localparam int YW  = $clog2(SCREEN_HEIGHT);
   localparam int AW  = $clog2(PIXEL_COUNT);
   localparam int NW  = 15;                       // pixels_drawn width
   localparam int COLW = 16;
   localparam int IDXW = 14;

   localparam int QDEPTH = 2;
   localparam int QPW    = $clog2(QDEPTH);
   localparam int QCW    = $clog2(QDEPTH + 1);

   localparam logic OP_DRAW = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic signed [EW-1:0] LIM_X = EW'((64'(SCREEN_WIDTH) << FRAC_BITS) - 64'd1);
   localparam logic signed [EW-1:0] LIM_Y = EW'((64'(SCREEN_HEIGHT) << FRAC_BITS) - 64'd1);

   typedef struct packed {
      logic                  op;
      logic signed [CW-1:0]  ax;
      logic signed [CW-1:0]  ay;
      logic signed [CW-1:0]  bx;
      logic signed [CW-1:0]  by;
      logic signed [CW-1:0]  cx;
      logic signed [CW-1:0]  cy;
      logic [COLW-1:0]       color;
      logic [IDXW-1:0]       rindex;
      logic signed [CW-1:0]  lo_x;
      logic signed [CW-1:0]  lo_y;
      logic [XW-1:0]         px0;
      logic [XW-1:0]         px1;
      logic [YW-1:0]         py0;
      logic [YW-1:0]         py1;
      logic                  empty;
   } efr_item_type;

   typedef struct packed {
      logic clearing;
   } efr_status_type;

endpackage

>>> src/efr_front.sv
// efr_front: classifies an accepted transaction (clamped box, empty test) and queues it
// depends on efr_pkg
`timescale 1ns / 1ps

module efr_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic                         req_operation,
   input  logic signed [31:0]           req_vertex_a_x,
   input  logic signed [31:0]           req_vertex_a_y,
   input  logic signed [31:0]           req_vertex_b_x,
   input  logic signed [31:0]           req_vertex_b_y,
   input  logic signed [31:0]           req_vertex_c_x,
   input  logic signed [31:0]           req_vertex_c_y,
   input  logic [15:0]                  req_fill_color,
   input  logic [13:0]                  req_read_index,
   input  logic                         pop,
   output efr_pkg::efr_item_type        head,
   output logic                         head_valid,
   output logic                         full
);
   import efr_pkg::*;

   efr_item_type            item;
   logic signed [EW-1:0]    mnx, mny, mxx, mxy;
   efr_item_type            q_ff [QDEPTH];
   logic [QPW-1:0]          wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]          cnt_ff, cnt_in;

   function automatic logic signed [EW-1:0] min3(input logic signed [CW-1:0] a,
      input logic signed [CW-1:0] b, input logic signed [CW-1:0] c);
      logic signed [CW-1:0] m;
      m = (a < b) ? a : b;
      m = (m < c) ? m : c;
      return EW'(m);
   endfunction

   function automatic logic signed [EW-1:0] max3(input logic signed [CW-1:0] a,
      input logic signed [CW-1:0] b, input logic signed [CW-1:0] c);
      logic signed [CW-1:0] m;
      m = (a > b) ? a : b;
      m = (m > c) ? m : c;
      return EW'(m);
   endfunction

   always_comb begin
      mnx = min3(req_vertex_a_x, req_vertex_b_x, req_vertex_c_x);
      mny = min3(req_vertex_a_y, req_vertex_b_y, req_vertex_c_y);
      mxx = max3(req_vertex_a_x, req_vertex_b_x, req_vertex_c_x);
      mxy = max3(req_vertex_a_y, req_vertex_b_y, req_vertex_c_y);
      if (mnx < 0) mnx = '0;
      if (mny < 0) mny = '0;
      if (mxx > LIM_X) mxx = LIM_X;
      if (mxy > LIM_Y) mxy = LIM_Y;
      item.op     = req_operation;
      item.ax     = req_vertex_a_x;
      item.ay     = req_vertex_a_y;
      item.bx     = req_vertex_b_x;
      item.by     = req_vertex_b_y;
      item.cx     = req_vertex_c_x;
      item.cy     = req_vertex_c_y;
      item.color  = req_fill_color;
      item.rindex = req_read_index;
      item.lo_x   = mnx[CW-1:0];
      item.lo_y   = mny[CW-1:0];
      item.px0    = mnx[FRAC_BITS+XW-1:FRAC_BITS];
      item.px1    = mxx[FRAC_BITS+XW-1:FRAC_BITS];
      item.py0    = mny[FRAC_BITS+YW-1:FRAC_BITS];
      item.py1    = mxy[FRAC_BITS+YW-1:FRAC_BITS];
      item.empty  = (mnx > mxx) || (mny > mxy);
   end

   assign head       = q_ff[rd_ptr_ff];
   assign head_valid = (cnt_ff != '0);
   assign full       = (cnt_ff == QCW'(QDEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + QCW'(push) - QCW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) q_ff[wr_ptr_ff] <= item;
   end

endmodule

>>> src/efr_back.sv
// efr_back: edge setup, pixel walk, framebuffer memory and result strobe
// depends on efr_pkg
`timescale 1ns / 1ps

module efr_back (
   input  logic                         clock,
   input  logic                         reset,
   input  efr_pkg::efr_item_type        head,
   input  logic                         head_valid,
   output logic                         pop,
   output efr_pkg::efr_status_type      status,
   output logic                         rsp_strobe,
   output logic [15:0]                  rsp_pixel_value,
   output logic [14:0]                  rsp_pixels_drawn
);
   import efr_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SETUP = 3'd2;
   localparam logic [2:0] S_WALK  = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0]              state_ff, state_in;
   efr_item_type            cur_ff, cur_in;
   logic [AW-1:0]           clr_ff, clr_in;
   logic [2:0]              k_ff, k_in;
   logic signed [PW-1:0]    mul_ff, mul_in;
   logic signed [EW-1:0]    r_ff [3];
   logic signed [EW-1:0]    r_in [3];
   logic signed [EW-1:0]    e_ff [3];
   logic signed [EW-1:0]    e_in [3];
   logic [XW-1:0]           x_ff, x_in;
   logic [YW-1:0]           y_ff, y_in;
   logic [AW-1:0]           base_ff, base_in;
   logic [NW-1:0]           cnt_ff, cnt_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic [COLW-1:0]         rsp_val_ff, rsp_val_in;
   logic [NW-1:0]           rsp_cnt_ff, rsp_cnt_in;

   logic [COLW-1:0]         mem [PIXEL_COUNT];
   logic [COLW-1:0]         rd_ff;
   logic                    mem_we;
   logic [AW-1:0]           mem_wa;
   logic [COLW-1:0]         mem_wd;
   logic [31:0]             idx32;
   logic                    idx_ok;

   logic signed [DW-1:0]    dx [3];
   logic signed [DW-1:0]    dy [3];
   logic signed [DW-1:0]    rx [3];
   logic signed [DW-1:0]    ry [3];
   logic signed [CW-1:0]    px [3];
   logic signed [CW-1:0]    py [3];
   logic signed [CW-1:0]    qx [3];
   logic signed [CW-1:0]    qy [3];
   logic signed [PW-1:0]    shifted;
   logic [2:0]              j;
   logic                    covered;

   // edges (b,c), (c,a), (a,b)
   always_comb begin
      px[0] = cur_ff.bx; py[0] = cur_ff.by; qx[0] = cur_ff.cx; qy[0] = cur_ff.cy;
      px[1] = cur_ff.cx; py[1] = cur_ff.cy; qx[1] = cur_ff.ax; qy[1] = cur_ff.ay;
      px[2] = cur_ff.ax; py[2] = cur_ff.ay; qx[2] = cur_ff.bx; qy[2] = cur_ff.by;
      for (int i = 0; i < 3; i++) begin
         dx[i] = DW'(qx[i]) - DW'(px[i]);
         dy[i] = DW'(qy[i]) - DW'(py[i]);
         rx[i] = DW'(cur_ff.lo_x) - DW'(px[i]);
         ry[i] = DW'(cur_ff.lo_y) - DW'(py[i]);
      end
   end

   assign idx32   = 32'(cur_ff.rindex);
   assign idx_ok  = (idx32 < 32'(PIXEL_COUNT));
   assign covered = !e_ff[0][EW-1] && !e_ff[1][EW-1] && !e_ff[2][EW-1];
   assign shifted = mul_ff >>> FRAC_BITS;
   assign j       = k_ff - 3'd1;

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      clr_in        = clr_ff;
      k_in          = k_ff;
      mul_in        = mul_ff;
      r_in          = r_ff;
      e_in          = e_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      base_in       = base_ff;
      cnt_in        = cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_val_in    = rsp_val_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      pop           = 1'b0;
      mem_we        = 1'b0;
      mem_wa        = base_ff + AW'(x_ff);
      mem_wd        = cur_ff.color;
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(PIXEL_COUNT - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (head_valid) begin
               pop     = 1'b1;
               cur_in  = head;
               k_in    = '0;
               cnt_in  = '0;
               x_in    = head.px0;
               y_in    = head.py0;
               base_in = AW'(32'(head.py0) * SCREEN_WIDTH);
               if (head.op == OP_READ) state_in = S_READ;
               else if (head.empty) state_in = S_RESP;
               else state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            case (k_ff[2:1])
               2'd0:    mul_in = k_ff[0] ? PW'(dy[0]) * PW'(rx[0]) : PW'(dx[0]) * PW'(ry[0]);
               2'd1:    mul_in = k_ff[0] ? PW'(dy[1]) * PW'(rx[1]) : PW'(dx[1]) * PW'(ry[1]);
               default: mul_in = k_ff[0] ? PW'(dy[2]) * PW'(rx[2]) : PW'(dx[2]) * PW'(ry[2]);
            endcase
            if (k_ff != 3'd0 && k_ff != 3'd7) begin
               if (!j[0]) r_in[j[2:1]] = EW'(shifted);
               else r_in[j[2:1]] = r_ff[j[2:1]] - EW'(shifted);
            end
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd7) begin
               e_in     = r_ff;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            mem_we = covered;
            cnt_in = cnt_ff + NW'(covered);
            if (x_ff == cur_ff.px1) begin
               if (y_ff == cur_ff.py1) begin
                  rsp_strobe_in = 1'b1;
                  rsp_val_in    = '0;
                  rsp_cnt_in    = cnt_in;
                  state_in      = S_IDLE;
               end else begin
                  y_in    = y_ff + 1'b1;
                  x_in    = cur_ff.px0;
                  base_in = base_ff + AW'(SCREEN_WIDTH);
                  for (int i = 0; i < 3; i++) begin
                     r_in[i] = r_ff[i] + EW'(dx[i]);
                     e_in[i] = r_in[i];
                  end
               end
            end else begin
               x_in = x_ff + 1'b1;
               for (int i = 0; i < 3; i++) e_in[i] = e_ff[i] - EW'(dy[i]);
            end
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_strobe_in = 1'b1;
            rsp_val_in    = (cur_ff.op == OP_READ && idx_ok) ? rd_ff : '0;
            rsp_cnt_in    = '0;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cur_ff     <= cur_in;
      k_ff       <= k_in;
      mul_ff     <= mul_in;
      r_ff       <= r_in;
      e_ff       <= e_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      base_ff    <= base_in;
      cnt_ff     <= cnt_in;
      rsp_val_ff <= rsp_val_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff <= mem[idx32[AW-1:0]];
   end

   assign status.clearing  = (state_ff == S_CLEAR);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_pixel_value  = rsp_val_ff;
   assign rsp_pixels_drawn = rsp_cnt_ff;

   a_no_rsp_while_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |=> !rsp_strobe_ff)
      else $error("result during clearing pass");
   a_walk_in_box: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> x_ff <= cur_ff.px1 && y_ff <= cur_ff.py1)
      else $error("walk left the bounding box");
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == S_IDLE && head_valid)
      else $error("queue popped outside idle");

endmodule

>>> src/edge_function_triangle_fill_core.sv
// edge_function_triangle_fill_core: top level, joins the classify queue and the draw engine
// depends on efr_pkg, efr_front, efr_back
//
// channel   direction  ports                                   handshake
// request   in         req_* fields, start                     start && !busy
// result    out        rsp_pixel_value, rsp_pixels_drawn       rsp_strobe, one cycle
//
// a read passes through the read and result states, and a draw with an empty box goes
// straight to the result state; any other draw runs edge setup on the shared multiplier,
// then walks each pixel of the clamped box (up to 16384)
// reset starts a pass that clears all 16384 framebuffer words; busy is high meanwhile
// two transactions queue ahead of the engine; busy rises when the queue is full
// results are never held: each one is shown for a single cycle
`timescale 1ns / 1ps

module edge_function_triangle_fill_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_operation,
   input  logic signed [31:0]  req_vertex_a_x,
   input  logic signed [31:0]  req_vertex_a_y,
   input  logic signed [31:0]  req_vertex_b_x,
   input  logic signed [31:0]  req_vertex_b_y,
   input  logic signed [31:0]  req_vertex_c_x,
   input  logic signed [31:0]  req_vertex_c_y,
   input  logic [15:0]         req_fill_color,
   input  logic [13:0]         req_read_index,
   output logic                rsp_strobe,
   output logic [15:0]         rsp_pixel_value,
   output logic [14:0]         rsp_pixels_drawn
);
   import efr_pkg::*;

   efr_item_type    head;
   efr_status_type  status;
   logic            head_valid, full, pop, push;

   assign busy = full || status.clearing;
   assign push = start && !busy;

   efr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .req_operation  (req_operation),
      .req_vertex_a_x (req_vertex_a_x),
      .req_vertex_a_y (req_vertex_a_y),
      .req_vertex_b_x (req_vertex_b_x),
      .req_vertex_b_y (req_vertex_b_y),
      .req_vertex_c_x (req_vertex_c_x),
      .req_vertex_c_y (req_vertex_c_y),
      .req_fill_color (req_fill_color),
      .req_read_index (req_read_index),
      .pop            (pop),
      .head           (head),
      .head_valid     (head_valid),
      .full           (full)
   );

   efr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .head_valid       (head_valid),
      .pop              (pop),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_pixels_drawn (rsp_pixels_drawn)
   );

endmodule
